>>> src/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types and constants for the SHA-256 digest block: word type, round
// constants, initial hash words and the control bundle to the round engine.
// ----------------------------------------------------------------------------
package sha256_pkg;

	localparam int unsigned BLK_WORDS  = 16;
	localparam int unsigned HASH_WORDS = 8;
	localparam int unsigned ROUNDS     = 64;

	typedef logic [31:0] word_t;

	// padding marker byte and the fill level that forces an extra block
	localparam logic [7:0] PAD_BYTE  = 8'h80;
	localparam logic [5:0] PAD_LIMIT = 6'd56;

	// index of the last byte slot and of the last digest word
	localparam logic [5:0] FILL_LAST = 6'd63;
	localparam logic [2:0] WORD_LAST = 3'd7;

	// round constants
	localparam word_t ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// initial chain value
	localparam word_t INIT_H [HASH_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// control from the sequencer to the round engine
	typedef struct packed {
		logic start; // load block and chain, begin 64 rounds
		logic init;  // return chain value to the initial hash words
	} core_ctrl_t;

endpackage

>>> src/sha256_core.sv
// ----------------------------------------------------------------------------
// sha256_core
// Round engine: one SHA-256 round per cycle with a rolling 16-word message
// schedule window; after the last round the result is folded into the chain.
// ----------------------------------------------------------------------------
module sha256_core
	import sha256_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  core_ctrl_t ctrl,
	input  word_t      blk   [BLK_WORDS],
	output word_t      chain [HASH_WORDS],
	output logic       done
);

	word_t      chain_q [HASH_WORDS];
	word_t      v_q     [HASH_WORDS];
	word_t      w_q     [BLK_WORDS];
	logic [5:0] rnd_q;
	logic       run_q;
	logic       fin_q;

	word_t big0, big1, choose, major, t1, t2, s0, s1, w_new;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	// one compression round and the next schedule word
	always_comb begin
		big1   = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		choose = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		big0   = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		major  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1     = v_q[7] + big1 + choose + ROUND_K[rnd_q] + w_q[0];
		t2     = big0 + major;
		s0     = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1     = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new  = s1 + w_q[9] + s0 + w_q[0];
	end

	// sequencing and chain value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= INIT_H;
			rnd_q   <= '0;
			run_q   <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			fin_q <= 1'b0;
			if (ctrl.init) begin
				chain_q <= INIT_H;
			end
			if (ctrl.start) begin
				rnd_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'(ROUNDS - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
			if (fin_q) begin
				for (int i = 0; i < HASH_WORDS; i++) begin
					chain_q[i] <= chain_q[i] + v_q[i];
				end
			end
		end
	end

	// working variables and schedule window
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			v_q <= chain_q;
			w_q <= blk;
		end else if (run_q) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
			for (int i = 0; i < BLK_WORDS - 1; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[BLK_WORDS - 1] <= w_new;
		end
	end

	assign chain = chain_q;
	assign done  = fin_q;

endmodule

>>> src/sha256_message_digest.sv
// ----------------------------------------------------------------------------
// sha256_message_digest
// SHA-256 over a byte stream: packs bytes into 64-byte blocks, pads the
// message, runs the round engine and streams out the eight digest words.
// ----------------------------------------------------------------------------
// Usage:
//   Input items carry one byte in s_tdata, s_tuser = 1 when the byte belongs
//   to the message, s_tlast = 1 on the final item. An item with s_tuser = 0
//   and s_tlast = 1 ends the message without a byte (empty message if first).
//   An item with neither flag is dropped.
//   A byte that neither completes a block nor ends the message leaves s_tready
//   high. The 64th byte of a block holds s_tready low through the load, 64
//   rounds of the single shared round unit and the fold into the chain value.
//   At message end the padded block is built and compressed; when 56 or more
//   bytes were left in the last block, a length-only block is compressed after it.
//   The digest then appears as eight output items, word 0 first; s_tready
//   stays low until all eight are taken. m_tready low simply holds the
//   current word. After the eighth word the block is back in its reset state.
//   Reset (arst_n low) loads the initial hash words and clears the byte and
//   bit counts; any message in progress is dropped.
// ----------------------------------------------------------------------------
module sha256_message_digest
	import sha256_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] msg_byte
	input  logic        s_tuser,  // byte_present
	input  logic        s_tlast,  // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [31:0] digest_word, [34:32] word_index, rest zero
	output logic        m_tlast   // last_word
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_GO   = 6'b000010,
		ST_HASH = 6'b000100,
		ST_PAD  = 6'b001000,
		ST_LEN  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t      state_q, after_q;
	logic [5:0]  fill_q;
	logic [63:0] count_q;
	logic [2:0]  idx_q;
	word_t       buf_q [BLK_WORDS];

	word_t       byte_word;
	word_t       pad_blk [BLK_WORDS];
	word_t       len_blk [BLK_WORDS];
	word_t       chain   [HASH_WORDS];
	logic        core_done;
	core_ctrl_t  ctrl;
	logic        in_acc, byte_wr, out_acc;
	logic [1:0]  lane;
	logic [4:0]  shift;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign byte_wr  = in_acc && s_tuser;
	assign out_acc  = m_tvalid && m_tready;

	assign ctrl.start = (state_q == ST_GO);
	assign ctrl.init  = out_acc && (idx_q == WORD_LAST);

	// byte merge into its word, big-endian; first byte clears the word
	assign lane  = fill_q[1:0];
	assign shift = {~lane, 3'b000};
	always_comb begin
		byte_word = (lane == 2'd0) ? '0 : buf_q[fill_q[5:2]];
		byte_word[shift +: 8] = s_tdata;
	end

	// padded block: keep bytes below the fill, marker at it, zeros above; bit count in the last two words when fill < 56
	always_comb begin
		logic [5:0] pos;
		pos = '0;
		for (int w = 0; w < BLK_WORDS; w++) begin
			for (int b = 0; b < 4; b++) begin
				pos = 6'(w * 4 + b);
				if (pos < fill_q) begin
					pad_blk[w][(3 - b) * 8 +: 8] = buf_q[w][(3 - b) * 8 +: 8];
				end else if (pos == fill_q) begin
					pad_blk[w][(3 - b) * 8 +: 8] = PAD_BYTE;
				end else begin
					pad_blk[w][(3 - b) * 8 +: 8] = 8'h00;
				end
			end
		end
		if (fill_q < PAD_LIMIT) begin
			pad_blk[BLK_WORDS - 2] = count_q[63:32];
			pad_blk[BLK_WORDS - 1] = count_q[31:0];
		end
	end

	// extra length-only block
	always_comb begin
		for (int w = 0; w < BLK_WORDS; w++) begin
			len_blk[w] = '0;
		end
		len_blk[BLK_WORDS - 2] = count_q[63:32];
		len_blk[BLK_WORDS - 1] = count_q[31:0];
	end

	// message sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			after_q <= ST_IDLE;
			fill_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_tuser) begin
							count_q <= count_q + 64'd8;
							if (fill_q == FILL_LAST) begin
								fill_q  <= '0;
								state_q <= ST_GO;
								after_q <= s_tlast ? ST_PAD : ST_IDLE;
							end else begin
								fill_q <= fill_q + 6'd1;
								if (s_tlast) begin
									state_q <= ST_PAD;
								end
							end
						end else if (s_tlast) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_GO: begin
					state_q <= ST_HASH;
				end
				ST_HASH: begin
					if (core_done) begin
						state_q <= after_q;
					end
				end
				ST_PAD: begin
					state_q <= ST_GO;
					after_q <= (fill_q >= PAD_LIMIT) ? ST_LEN : ST_OUT;
				end
				ST_LEN: begin
					state_q <= ST_GO;
					after_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_acc) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == WORD_LAST) begin
							state_q <= ST_IDLE;
							fill_q  <= '0;
							count_q <= '0;
							idx_q   <= '0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// block buffer writes
	always_ff @(posedge clk) begin
		if (byte_wr) begin
			buf_q[fill_q[5:2]] <= byte_word;
		end else if (state_q == ST_PAD) begin
			buf_q <= pad_blk;
		end else if (state_q == ST_LEN) begin
			buf_q <= len_blk;
		end
	end

	sha256_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.blk    (buf_q),
		.chain  (chain),
		.done   (core_done)
	);

	// digest output
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = {5'b00000, idx_q, chain[idx_q]};
	assign m_tlast  = (idx_q == WORD_LAST);

endmodule

>>> bench/sha256_message_digest_tb.sv
// ----------------------------------------------------------------------------
// sha256_message_digest_tb
// Self-checking bench for the byte-stream SHA-256 block. A short table of
// directed items (empty message, "abc", ignored items, byte extremes, ends
// with and without a byte) is followed by two random messages, one that ends
// exactly on a block boundary and one whose tail needs the extra padding
// block, with stray items and random end styles. Both stream sides idle and
// stall at random. Every digest word is checked against a bit-accurate
// SHA-256 predictor kept inside the bench, or a known digest from the table.
// ----------------------------------------------------------------------------
module sha256_message_digest_tb
	import sha256_pkg::*;
();

	localparam int CYCLE_LIMIT   = 400000;
	localparam int TAIL_CYCLES   = 200;
	localparam int N_DIRECTED    = 14;

	// well-known digests of the empty message and of "abc"
	localparam logic [255:0] EMPTY_DIGEST =
		256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
	localparam logic [255:0] ABC_DIGEST =
		256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

	typedef struct {
		word_t      digest_word;
		logic [2:0] word_index;
		logic       last_word;
	} digest_out_t;

	typedef struct packed {
		logic [7:0]   data;
		logic         present;
		logic         last;
		logic         known;
		logic [255:0] digest;
	} stim_row_t;

	// directed table: byte, present, last, digest known, digest
	localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		'{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // empty message
		'{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
		'{8'h55, 1'b0, 1'b0, 1'b0, 256'h0},        // ignored inside a message
		'{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
		'{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},    // byte and end together
		'{8'h00, 1'b1, 1'b0, 1'b0, 256'h0},
		'{8'hff, 1'b1, 1'b0, 1'b0, 256'h0},
		'{8'h80, 1'b1, 1'b0, 1'b0, 256'h0},
		'{8'h7f, 1'b1, 1'b0, 1'b0, 256'h0},
		'{8'ha5, 1'b0, 1'b1, 1'b0, 256'h0},        // end without a byte
		'{8'hff, 1'b1, 1'b1, 1'b0, 256'h0},
		'{8'h00, 1'b1, 1'b1, 1'b0, 256'h0},
		'{8'h3c, 1'b0, 1'b0, 1'b0, 256'h0},        // ignored between messages
		'{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST}   // back to reset state
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;  // [7:0] msg_byte
	logic        s_tuser;  // byte_present
	logic        s_tlast;  // end_of_message
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;  // [31:0] digest_word, [34:32] word_index
	logic        m_tlast;  // last_word

	// predictor state
	word_t       chain_words [HASH_WORDS];
	word_t       block_words [BLK_WORDS];
	logic [63:0] bit_total;
	int unsigned fill;

	digest_out_t digest_due [$];
	int          error_count = 0;
	int          cycle_count = 0;
	int          src_calm = 0;
	int          sink_calm = 0;

	sha256_message_digest DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #2 clk = ~clk;

	// run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// idle length per item, with occasional stretches of back-to-back items
	function automatic int pick_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 12);
	endfunction

	function automatic word_t rotr(word_t x, int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// place one byte big-endian in the block, clearing a word on its first byte
	task automatic store_byte(input int unsigned pos, input logic [7:0] b);
		int unsigned w;
		int unsigned sh;
		w  = pos >> 2;
		sh = (3 - (pos & 3)) * 8;
		if ((pos & 3) == 0)
			block_words[w] = '0;
		block_words[w][sh +: 8] = b;
	endtask

	// 64 rounds over block_words, folded into chain_words
	task automatic compress_chain();
		word_t sched [ROUNDS];
		word_t v [HASH_WORDS];
		word_t s0, s1, t1, t2;
		int    r;
		for (r = 0; r < BLK_WORDS; r++)
			sched[r] = block_words[r];
		for (r = BLK_WORDS; r < ROUNDS; r++) begin
			s0 = rotr(sched[r-15], 7) ^ rotr(sched[r-15], 18) ^ (sched[r-15] >> 3);
			s1 = rotr(sched[r-2], 17) ^ rotr(sched[r-2], 19) ^ (sched[r-2] >> 10);
			sched[r] = s1 + sched[r-7] + s0 + sched[r-16];
		end
		v = chain_words;
		for (r = 0; r < ROUNDS; r++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + sched[r];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (r = 0; r < HASH_WORDS; r++)
			chain_words[r] = chain_words[r] + v[r];
	endtask

	task automatic hash_restart();
		chain_words = INIT_H;
		bit_total   = '0;
		fill        = 0;
	endtask

	// absorb one accepted item; on end of message pad, finish and give the digest
	task automatic hash_absorb(input logic [7:0] data, input logic present,
			input logic last, output bit done, output word_t dig [HASH_WORDS]);
		int unsigned p;
		int          i;
		done = 1'b0;
		if (present) begin
			store_byte(fill, data);
			bit_total = bit_total + 64'd8;
			fill++;
			if (fill == 64) begin
				compress_chain();
				fill = 0;
			end
		end
		if (!last)
			return;
		store_byte(fill, PAD_BYTE);
		for (p = fill + 1; p < 64; p++)
			store_byte(p, 8'h00);
		// no room for the length: extra padding block
		if (fill >= PAD_LIMIT) begin
			compress_chain();
			for (i = 0; i < BLK_WORDS; i++)
				block_words[i] = '0;
		end
		block_words[14] = bit_total[63:32];
		block_words[15] = bit_total[31:0];
		compress_chain();
		dig  = chain_words;
		done = 1'b1;
		hash_restart();
	endtask

	// drive one input item, wait for acceptance, queue the digest it causes
	task automatic send_item(input logic [7:0] data, input logic present,
			input logic last, input logic known, input logic [255:0] fixed);
		int          gap;
		int          k;
		bit          done;
		word_t       dig [HASH_WORDS];
		digest_out_t d;
		gap = pick_wait(src_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= present;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		hash_absorb(data, present, last, done, dig);
		if (done) begin
			for (k = 0; k < HASH_WORDS; k++) begin
				d.digest_word = known ? fixed[255 - 32*k -: 32] : dig[k];
				d.word_index  = 3'(k);
				d.last_word   = (3'(k) == WORD_LAST);
				digest_due.push_back(d);
			end
		end
	endtask

	// output side: random stalls per item
	initial begin
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin : sink_loop
			int stall;
			stall = pick_wait(sink_calm);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	// digest word check
	always @(posedge clk) begin : check_digest
		digest_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (digest_due.size() == 0) begin
				error_count++;
				$display("%0t unexpected digest word: expected none, actual %h idx %0d last %b",
					$time, m_tdata[31:0], m_tdata[34:32], m_tlast);
			end else begin
				want = digest_due.pop_front();
				if (m_tdata[31:0] !== want.digest_word) begin
					error_count++;
					$display("%0t digest_word: expected %h, actual %h",
						$time, want.digest_word, m_tdata[31:0]);
				end
				if (m_tdata[34:32] !== want.word_index) begin
					error_count++;
					$display("%0t word_index: expected %0d, actual %0d",
						$time, want.word_index, m_tdata[34:32]);
				end
				if (m_tlast !== want.last_word) begin
					error_count++;
					$display("%0t last_word: expected %b, actual %b",
						$time, want.last_word, m_tlast);
				end
			end
		end
	end

	// stimulus
	initial begin
		int  row;
		int  len;
		int  k;
		int  msg;
		bit  sep_end;
		bit  edge_first;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= 1'b0;
		s_tlast  <= 1'b0;
		hash_restart();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (row = 0; row < N_DIRECTED; row++)
			send_item(DIRECTED_ROWS[row].data, DIRECTED_ROWS[row].present,
				DIRECTED_ROWS[row].last, DIRECTED_ROWS[row].known,
				DIRECTED_ROWS[row].digest);

		// random messages: one ending exactly on a block boundary, one whose
		// tail needs the extra padding block, in random order
		edge_first = ($urandom_range(0, 1) == 1);
		for (msg = 0; msg < 2; msg++) begin
			if ((msg == 0) == edge_first)
				len = 64;
			else
				len = $urandom_range(56, 63);
			sep_end = ($urandom_range(0, 1) == 1);
			for (k = 0; k < len; k++) begin
				// stray item with neither flag
				if ($urandom_range(0, 9) == 0)
					send_item(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
				send_item(8'($urandom), 1'b1, !sep_end && (k == len - 1), 1'b0, '0);
			end
			if (sep_end)
				send_item(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
		end
		s_tvalid <= 1'b0;

		// drain
		while (digest_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> sim.f
src/sha256_pkg.sv
src/sha256_core.sv
src/sha256_message_digest.sv
bench/sha256_message_digest_tb.sv
